// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; the user supplies clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define WTCM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define WTCM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/wtcm_pkg.sv =====
// Package of the wall texture column mapper: widths, codes and helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wtcm_pkg;

	// Fixed-point formats.
	localparam int FRAC_BITS   = 16;
	localparam int DIR_FRAC    = 14;
	localparam int MAX_TEX_DIM = 4096;

	// Field and register widths.
	localparam int CFG_W   = 13;
	localparam int COL_W   = 12;
	localparam int TEX_W   = 12;
	localparam int Y_W     = 15;
	localparam int ROW_W   = 16;
	localparam int POS_W   = 24;
	localparam int DIRV_W  = 16;
	localparam int WH_W    = 15;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Derived datapath widths.
	localparam int STEP_W  = CFG_W + FRAC_BITS;
	localparam int TPOS_W  = 48;
	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int BASE_W  = 17;
	localparam int CNT_W   = $clog2(STEP_W + 1);

	// Register indexes.
	localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SCR_HEIGHT = 2'd2;

	// Command codes.
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Request to the divider.
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] dividend;
		logic [WH_W-1:0]   divisor;
	} div_req_t;

	// Status returned by the divider.
	typedef struct packed {
		logic              busy;
		logic [STEP_W-1:0] quotient;
	} div_rsp_t;

	// A zero texture size acts as one, a size above the maximum as the maximum.
	function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		if (v == '0)
			r = CFG_W'(1);
		else if (v > CFG_W'(MAX_TEX_DIM))
			r = CFG_W'(MAX_TEX_DIM);
		else
			r = v;
		return r;
	endfunction

endpackage

// ===== rtl/core/wall_texture_column_mapper.sv =====
// Wall texture column mapper: top level with sequencer, state and register port.
// Depends on wtcm_pkg, wtcm_mul and wtcm_div.
`timescale 1ns / 1ps

// Use of the block:
// Items arrive on the item channel (item_valid / item_ready) and results leave on
// the res channel (res_valid / res_ready); a word moves when valid and ready are
// both high at a rising edge. A begin word (cmd low) loads one screen column's ray:
// the shared multiplier forms the wall hit, the texture column and the start
// position in turn, while the divider forms the vertical step. A begin word holds
// item_ready low until the sequence is back in idle, through the one-bit iterations
// of the divider, and gives no result. A step word (cmd high), while a column is
// active, loads one pixel word into the output register at the edge that takes it,
// so steps run at one word per cycle while res_ready is high. A step with no active
// column is taken and dropped. The output register holds its word while res_ready
// is low; the block then takes a new item only in the cycle the waiting word leaves.
// Registers texture_width, texture_height and screen_height sit at byte addresses
// 0, 4 and 8 of the APB port; the user must write them only while the block is idle,
// and the block does not enforce this. Reset clears the column state and the output
// register and restores the register defaults 64, 64 and 720; no clearing pass is needed.
module wall_texture_column_mapper
	import wtcm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration port.
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	// Item channel.
	input  logic                     item_valid,
	output logic                     item_ready,
	input  logic                     cmd,
	input  logic [COL_W-1:0]         column,
	input  logic                     hit_side,
	input  logic [POS_W-1:0]         player_x,
	input  logic [POS_W-1:0]         player_y,
	input  logic signed [DIRV_W-1:0] dir_x,
	input  logic signed [DIRV_W-1:0] dir_y,
	input  logic [POS_W-1:0]         distance,
	input  logic [WH_W-1:0]          wall_height,
	input  logic signed [ROW_W-1:0]  span_start,
	input  logic signed [ROW_W-1:0]  span_end,
	// Result channel.
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [COL_W-1:0]         screen_x,
	output logic [Y_W-1:0]           screen_y,
	output logic [TEX_W-1:0]         texel_col,
	output logic [TEX_W-1:0]         texel_row,
	output logic                     last_row
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HIT,
		S_FRAC,
		S_COL,
		S_TEXCOL,
		S_DIV,
		S_POS,
		S_POSW
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CFG_W-1:0] tex_w_q;
	logic [CFG_W-1:0] tex_h_q;
	logic [CFG_W-1:0] scr_h_q;
	logic             cfg_wr;

	// Column state.
	logic                     active_q;
	logic [COL_W-1:0]         cur_col_q;
	logic signed [ROW_W-1:0]  cur_row_q;
	logic signed [ROW_W-1:0]  end_row_q;
	logic [TEX_W-1:0]         texcol_q;
	logic [STEP_W-1:0]        row_step_q;
	logic signed [TPOS_W-1:0] tex_pos_q;

	// Begin word held during the sequence.
	logic [COL_W-1:0]         b_col_q;
	logic [FRAC_BITS-1:0]     b_plo_q;
	logic signed [DIRV_W-1:0] b_dir_q;
	logic [POS_W-1:0]         b_dist_q;
	logic [WH_W-1:0]          b_wh_q;
	logic signed [ROW_W-1:0]  b_s0_q;
	logic signed [ROW_W-1:0]  b_s1_q;
	logic                     b_mirror_q;
	logic [FRAC_BITS-1:0]     frac_q;

	// Output register.
	logic             res_valid_q;
	logic [COL_W-1:0] res_x_q;
	logic [Y_W-1:0]   res_y_q;
	logic [TEX_W-1:0] res_tcol_q;
	logic [TEX_W-1:0] res_trow_q;
	logic             res_last_q;

	// Shared units.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	// Derived values.
	logic                     take;
	logic                     take_begin;
	logic                     take_step;
	logic [CFG_W-1:0]         tw_eff;
	logic [CFG_W-1:0]         th_eff;
	logic [WH_W-1:0]          wh_in;
	logic signed [ROW_W-1:0]  s0_clip;
	logic signed [BASE_W-1:0] base_m;
	logic [CFG_W-1:0]         col_raw;
	logic [CFG_W-1:0]         col_fix;
	logic [FRAC_BITS-1:0]     frac_nxt;
	logic [TPOS_W-FRAC_BITS-2:0] row_int;
	logic [TEX_W-1:0]         row_clamp;
	logic                     is_last;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign item_ready = (state_q == S_IDLE) && (!res_valid_q || res_ready);
	assign take       = item_valid && item_ready;
	assign take_begin = take && (cmd == CMD_BEGIN);
	assign take_step  = take && (cmd == CMD_STEP);

	assign tw_eff = eff_dim(tex_w_q);
	assign th_eff = eff_dim(tex_h_q);
	assign wh_in  = (wall_height == '0) ? WH_W'(1) : wall_height;

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_TEX_WIDTH:  prdata = DATA_W'(tex_w_q);
			REG_TEX_HEIGHT: prdata = DATA_W'(tex_h_q);
			REG_SCR_HEIGHT: prdata = DATA_W'(scr_h_q);
			default:        prdata = '0;
		endcase
	end

	// Start the step division directly from the begin word.
	assign div_req.start    = take_begin;
	assign div_req.dividend = {th_eff, {FRAC_BITS{1'b0}}};
	assign div_req.divisor  = wh_in;

	// Start position factor; a clipped top starts at row zero and the factor uses that row.
	always_comb begin
		s0_clip = (b_s0_q < 0) ? '0 : b_s0_q;
		base_m  = BASE_W'(s0_clip) - BASE_W'(scr_h_q[CFG_W-1:1])
			+ BASE_W'(b_wh_q[WH_W-1:1]);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			S_HIT: begin
				mul_a = MUL_A_W'(b_dir_q);
				mul_b = $signed({1'b0, b_dist_q});
			end
			S_COL: begin
				mul_a = $signed(MUL_A_W'(frac_q));
				mul_b = $signed(MUL_B_W'(tw_eff));
			end
			S_POS: begin
				mul_a = $signed({1'b0, row_step_q});
				mul_b = MUL_B_W'(base_m);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Wall fraction and mirrored texture column from the registered products.
	always_comb begin
		frac_nxt = b_plo_q + mul_p[FRAC_BITS+DIR_FRAC-1:DIR_FRAC];
		col_raw  = mul_p[FRAC_BITS+CFG_W-1:FRAC_BITS];
		col_fix  = b_mirror_q ? (tw_eff - CFG_W'(1) - col_raw) : col_raw;
	end

	// Texture row of the current pixel, clamped to the texture height.
	always_comb begin
		row_int = tex_pos_q[TPOS_W-2:FRAC_BITS];
		if (tex_pos_q < 0)
			row_clamp = '0;
		else if (row_int >= (TPOS_W-FRAC_BITS-1)'(th_eff))
			row_clamp = TEX_W'(th_eff - CFG_W'(1));
		else
			row_clamp = row_int[TEX_W-1:0];
		is_last = (cur_row_q >= end_row_q);
	end

	// Sequencer, column state, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tex_w_q     <= CFG_W'(64);
			tex_h_q     <= CFG_W'(64);
			scr_h_q     <= CFG_W'(720);
			active_q    <= 1'b0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			end_row_q   <= '0;
			texcol_q    <= '0;
			row_step_q  <= '0;
			tex_pos_q   <= '0;
			b_col_q     <= '0;
			b_plo_q     <= '0;
			b_dir_q     <= '0;
			b_dist_q    <= '0;
			b_wh_q      <= '0;
			b_s0_q      <= '0;
			b_s1_q      <= '0;
			b_mirror_q  <= 1'b0;
			frac_q      <= '0;
			res_valid_q <= 1'b0;
			res_x_q     <= '0;
			res_y_q     <= '0;
			res_tcol_q  <= '0;
			res_trow_q  <= '0;
			res_last_q  <= 1'b0;
		end else begin
			// Register writes.
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_TEX_WIDTH:  tex_w_q <= pwdata[CFG_W-1:0];
					REG_TEX_HEIGHT: tex_h_q <= pwdata[CFG_W-1:0];
					REG_SCR_HEIGHT: scr_h_q <= pwdata[CFG_W-1:0];
					default: ;
				endcase
			end

			// A step of an active column fills the output register; a taken word empties it.
			if (take_step && active_q)
				res_valid_q <= 1'b1;
			else if (res_valid_q && res_ready)
				res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (take_begin) begin
						active_q   <= 1'b0;
						b_col_q    <= column;
						b_plo_q    <= hit_side ? player_x[FRAC_BITS-1:0]
							: player_y[FRAC_BITS-1:0];
						b_dir_q    <= hit_side ? dir_x : dir_y;
						b_dist_q   <= distance;
						b_wh_q     <= wh_in;
						b_s0_q     <= span_start;
						b_s1_q     <= span_end;
						b_mirror_q <= (!hit_side && (dir_x < 0)) || (hit_side && (dir_y > 0));
						state_q    <= S_HIT;
					end else if (take_step && active_q) begin
						// One pixel word per step while the column runs.
						res_x_q     <= cur_col_q;
						res_y_q     <= cur_row_q[Y_W-1:0];
						res_tcol_q  <= texcol_q;
						res_trow_q  <= row_clamp;
						res_last_q  <= is_last;
						tex_pos_q   <= tex_pos_q + TPOS_W'(row_step_q);
						if (is_last)
							active_q <= 1'b0;
						else
							cur_row_q <= cur_row_q + ROW_W'(1);
					end
				end
				S_HIT: begin
					state_q <= S_FRAC;
				end
				S_FRAC: begin
					frac_q  <= frac_nxt;
					state_q <= S_COL;
				end
				S_COL: begin
					state_q <= S_TEXCOL;
				end
				S_TEXCOL: begin
					texcol_q <= col_fix[TEX_W-1:0];
					state_q  <= S_DIV;
				end
				S_DIV: begin
					if (!div_rsp.busy) begin
						row_step_q <= div_rsp.quotient;
						state_q    <= S_POS;
					end
				end
				S_POS: begin
					state_q <= S_POSW;
				end
				S_POSW: begin
					tex_pos_q <= mul_p[TPOS_W-1:0];
					cur_col_q <= b_col_q;
					cur_row_q <= s0_clip;
					end_row_q <= b_s1_q;
					active_q  <= (b_s1_q >= s0_clip);
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	wtcm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	wtcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign res_valid = res_valid_q;
	assign screen_x  = res_x_q;
	assign screen_y  = res_y_q;
	assign texel_col = res_tcol_q;
	assign texel_row = res_trow_q;
	assign last_row  = res_last_q;

endmodule

// ===== rtl/core/wtcm_mul.sv =====
// Shared signed multiplier of the column mapper with a registered product.
// Depends on wtcm_pkg for the operand widths.
`timescale 1ns / 1ps

module wtcm_mul
	import wtcm_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_q
);

	// One product per cycle, registered before any further use.
	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

// ===== rtl/core/wtcm_div.sv =====
// Restoring divider that forms the vertical texture step, one quotient bit per cycle.
// Depends on wtcm_pkg for widths and the request and status structs.
`timescale 1ns / 1ps

module wtcm_div
	import wtcm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] quo_q;
	logic [WH_W-1:0]   rem_q;
	logic [WH_W-1:0]   dvs_q;
	logic [WH_W:0]     trial;
	logic [WH_W+1:0]   diff;
	logic              borrow;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial  = {rem_q, quo_q[STEP_W-1]};
		diff   = {1'b0, trial} - {2'b00, dvs_q};
		borrow = diff[WH_W+1];
	end

	// Iteration: shift in one dividend bit and settle one quotient bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEP_W);
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[STEP_W-2:0], ~borrow};
			rem_q <= borrow ? trial[WH_W-1:0] : diff[WH_W-1:0];
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/core/wtcm_checker.sv =====
// Port-level checker of the wall texture column mapper and its bind to the top level.
// Depends on wtcm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wtcm_checker
	import wtcm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             cmd,
	input logic             res_valid,
	input logic             res_ready,
	input logic [COL_W-1:0] screen_x,
	input logic [Y_W-1:0]   screen_y,
	input logic [TEX_W-1:0] texel_col,
	input logic [TEX_W-1:0] texel_row,
	input logic             last_row
);

	logic             begin_take;
	logic             res_take;
	logic             prev_ok_q;
	logic [COL_W-1:0] prev_x_q;
	logic [Y_W-1:0]   prev_y_q;
	logic [TEX_W-1:0] prev_col_q;

	assign begin_take = item_valid && item_ready && (cmd == CMD_BEGIN);
	assign res_take   = res_valid && res_ready;

	// Track the last taken pixel word of a column that is still running.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ok_q  <= 1'b0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_col_q <= '0;
		end else if (begin_take) begin
			prev_ok_q <= 1'b0;
		end else if (res_take) begin
			prev_ok_q  <= !last_row;
			prev_x_q   <= screen_x;
			prev_y_q   <= screen_y;
			prev_col_q <= texel_col;
		end
	end

	// A stalled pixel word keeps its row, texture row and last-row flag.
	`WTCM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable(screen_y) && $stable(texel_row) && $stable(last_row),
		"pixel word changed while stalled")

	// A begin word occupies the sequencer, so no item is taken next cycle.
	`WTCM_ASSERT_NEXT(a_begin_busy, begin_take, !item_ready,
		"item taken right after a begin word")

	// A new pixel word only follows a taken item.
	`WTCM_ASSERT(a_res_cause, $rose(res_valid) |-> $past(item_valid && item_ready),
		"pixel word without a step word")

	// Within a column, rows advance by one with the same column and texture column.
	`WTCM_ASSERT(a_res_walk, (res_take && prev_ok_q) |->
		(screen_x == prev_x_q && screen_y == prev_y_q + Y_W'(1) && texel_col == prev_col_q),
		"pixel word breaks the column walk")

endmodule

bind wall_texture_column_mapper wtcm_checker u_wtcm_checker (.*);
